// ----- design/md_pkg.sv -----
// Shared types and constants for the distance engine.
package md_pkg;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned DIST_W = 48;
  localparam int unsigned ACC_W  = 132;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT = 1'b1;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
    logic              negative_form;
  } md_result_t;

  typedef struct packed {
    logic req_type;
    logic [1:0] row_index;
    logic [3:0][ELEM_W-1:0] first_elem;
    logic [3:0][ELEM_W-1:0] second_elem;
  } md_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch item, form differences
    logic term;       // form term i,j
    logic [1:0] ti;
    logic [1:0] tj;
    logic clear_acc;
    logic accum;      // add the registered term
    logic sqrt_start;
    logic sqrt_step;
    logic finish;     // form the result
  } md_cmd_t;

  typedef struct packed {
    logic sqrt_last;
  } md_stat_t;
endpackage

// ----- design/md_if.sv -----
// Valid/ready channel carrying one payload item.
interface md_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/md_ram.sv -----
// Generic single-port-write RAM with registered read.
module md_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/md_datapath.sv -----
// Datapath: differences, one matrix term per cycle, accumulator, square root.
module md_datapath #(
  parameter int unsigned DIM = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  md_pkg::md_cmd_t    cmd,
  input  md_pkg::md_item_t   item,
  input  logic               take_root,
  output md_pkg::md_stat_t   stat,
  output md_pkg::md_result_t result
);
  import md_pkg::*;

  localparam int unsigned SQ_W = 49;
  localparam int unsigned RW = 100; // remainder width for the root

  logic signed [DIFF_W-1:0] diff_r [4];
  logic [3:0] negd_r;
  logic [DIFF_W-1:0] absd_r [4];
  logic [1:0] tj_r;
  logic term_v_r, term2_v_r;
  logic [65:0] dd_r;
  logic dsign_r;
  logic [ELEM_W-1:0] m_rd;
  logic [97:0] prod_r;
  logic psign_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [SQ_W-1:0] root_r;
  logic [RW-1:0] rem_r;
  logic [5:0] sbit_r;
  md_result_t res_r;
  md_result_t res_nxt;

  // matrix memory: a load writes one row at address row_index, in one RAM per column;
  // only the columns and rows below DIM are written.
  logic [ELEM_W-1:0] col_rd [4];
  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_col
      md_ram #(.WIDTH(ELEM_W), .DEPTH(4)) u_ram (
        .clk(clk),
        .we(cmd.capture && item.req_type == REQ_LOAD && g < DIM
            && 32'(item.row_index) < DIM),
        .waddr(item.row_index), .wdata(item.first_elem[g]),
        .raddr(cmd.ti), .rdata(col_rd[g]));
    end
  endgenerate
  assign m_rd = col_rd[tj_r];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int k = 0; k < 4; k++) begin
        diff_r[k] <= DIFF_W'($signed(item.first_elem[k])) -
                     DIFF_W'($signed(item.second_elem[k]));
      end
    end
  end
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      negd_r[k] = diff_r[k][DIFF_W-1];
      absd_r[k] = negd_r[k] ? DIFF_W'(-diff_r[k]) : DIFF_W'(diff_r[k]);
    end
  end

  // stage 1: |di|*|dj| while the RAM reads M[i][*]
  always_ff @(posedge clk) begin
    term_v_r <= cmd.term;
    tj_r <= cmd.tj;
    if (cmd.term) begin
      dd_r <= 66'(absd_r[cmd.ti]) * 66'(absd_r[cmd.tj]);
      dsign_r <= negd_r[cmd.ti] ^ negd_r[cmd.tj];
    end
  end

  // stage 2: times |m|, split into two 33x32 products
  logic [ELEM_W-1:0] am;
  assign am = m_rd[ELEM_W-1] ? ELEM_W'(-m_rd) : m_rd;
  logic [65:0] plo_r, phi_r;
  logic psig_r;
  always_ff @(posedge clk) begin
    term2_v_r <= term_v_r;
    if (term_v_r) begin
      plo_r <= 66'(dd_r[32:0]) * 66'(am);
      phi_r <= 66'(dd_r[65:33]) * 66'(am);
      psig_r <= dsign_r ^ m_rd[ELEM_W-1];
    end
  end
  assign prod_r = 98'(plo_r) + (98'(phi_r) << 33);
  assign psign_r = psig_r;

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) acc_r <= '0;
    else if (cmd.accum && term2_v_r)
      acc_r <= psign_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
  end

  // bit-serial restoring square root, one result bit per cycle
  logic [RW-1:0] rem_nxt;
  logic [SQ_W-1:0] root_nxt;
  always_comb begin
    rem_nxt = rem_r;
    root_nxt = root_r;
    if ((RW'(root_r) << (sbit_r + 1)) + (RW'(1) << (2 * sbit_r)) <= rem_r) begin
      rem_nxt = rem_r - ((RW'(root_r) << (sbit_r + 1)) + (RW'(1) << (2 * sbit_r)));
      root_nxt = root_r | (SQ_W'(1) << sbit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rem_r <= RW'(acc_r[ACC_W-2:0] >> FRAC_BITS);
      root_r <= '0;
      sbit_r <= 6'(SQ_W - 1);
    end else if (cmd.sqrt_step) begin
      rem_r <= rem_nxt;
      root_r <= root_nxt;
      sbit_r <= sbit_r - 6'd1;
    end
  end
  assign stat.sqrt_last = (sbit_r == 6'd0);

  // root tracked incrementally: root_r holds bits above sbit; shifts use it relative
  logic [ACC_W-1:0] sq;
  assign sq = ACC_W'(acc_r) >> (2 * FRAC_BITS);
  always_comb begin
    res_nxt = '0;
    if (acc_r[ACC_W-1]) begin
      res_nxt.negative_form = 1'b1;
    end else if (take_root) begin
      if (root_nxt[SQ_W-1]) begin
        res_nxt.distance = '1;
        res_nxt.saturated = 1'b1;
      end else begin
        res_nxt.distance = root_nxt[DIST_W-1:0];
      end
    end else if (sq[ACC_W-1:DIST_W] != '0) begin
      res_nxt.distance = '1;
      res_nxt.saturated = 1'b1;
    end else begin
      res_nxt.distance = sq[DIST_W-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.finish) res_r <= res_nxt;
  end
  assign result = res_r;
endmodule

// ----- design/md_ctrl.sv -----
// Controller: sequences the terms, the root and the result handshake.
module md_ctrl #(
  parameter int unsigned DIM = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_req_type,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [2:0]       dims,
  input  logic             take_root,
  input  md_pkg::md_stat_t stat,
  output md_pkg::md_cmd_t  cmd
);
  import md_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TERM  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_SQRT  = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] i_r, j_r, i_nxt, j_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic [2:0] n_r, n_nxt;
  logic [2:0] n_eff;

  assign n_eff = (32'(dims) > DIM) ? 3'(DIM) : dims;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r; drain_nxt = drain_r; n_nxt = n_r;
    cmd = '0;
    cmd.ti = i_r;
    cmd.tj = j_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_req_type == REQ_COMPUTE) begin
            cmd.clear_acc = 1'b1;
            i_nxt = '0; j_nxt = '0; n_nxt = n_eff;
            state_nxt = (n_eff == 3'd0) ? S_DRAIN : S_TERM;
            drain_nxt = 2'd3;
          end
        end
      end
      S_TERM: begin
        cmd.term = 1'b1;
        cmd.accum = 1'b1;
        if (3'(j_r) + 3'd1 == n_r) begin
          j_nxt = '0;
          if (3'(i_r) + 3'd1 == n_r) begin
            state_nxt = S_DRAIN;
            drain_nxt = 2'd3;
          end else i_nxt = i_r + 2'd1;
        end else j_nxt = j_r + 2'd1;
      end
      S_DRAIN: begin
        cmd.accum = 1'b1;
        drain_nxt = drain_r - 2'd1;
        if (drain_r == 2'd1) begin
          if (take_root) begin
            cmd.sqrt_start = 1'b1;
            state_nxt = S_SQRT;
          end else state_nxt = S_FIN;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_last) begin
          cmd.finish = 1'b1;
          state_nxt = S_OUT;
        end else cmd.sqrt_step = 1'b1;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0; j_r <= '0; drain_r <= '0; n_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt; j_r <= j_nxt; drain_r <= drain_nxt; n_r <= n_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
endmodule

// ----- design/mahalanobis_distance.sv -----
// Top level of the Mahalanobis distance engine.
// A load item (req_type 0) writes one row of the 4x4 inverse covariance matrix and gives
// no result. A compute item forms d = a - b, accumulates d^T M d one matrix term per cycle
// through the registered multiply stages, then in root mode runs a bit-serial square root
// over 49 result bits, one bit per cycle. A new item is accepted only once the result of
// the last compute item has been taken on out_ready. Rows must be loaded before use.
module mahalanobis_distance #(
  parameter int unsigned DIM = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  md_if.sink   in_ch,
  md_if.source out_ch,
  input  logic                            cfg_we,
  input  logic [md_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [md_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import md_pkg::*;

  logic [2:0] dims_r;
  logic take_root_r;
  md_cmd_t cmd;
  md_stat_t stat;
  md_item_t item;
  md_result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 3'd4;
      take_root_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIMS: dims_r <= cfg_data;
        REG_ROOT: take_root_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item = in_ch.data;

  md_ctrl #(.DIM(DIM)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_req_type(item.req_type), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .dims(dims_r), .take_root(take_root_r), .stat, .cmd);

  md_datapath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .cmd, .item, .take_root(take_root_r), .stat, .result(res));

  assign out_ch.data = res;
endmodule

// ----- tb/tb_mahalanobis_distance.sv -----
// Testbench for the Mahalanobis distance engine: random and directed items, scoreboard check.
module tb_mahalanobis_distance;
  timeunit 1ns;
  timeprecision 1ps;
  import md_pkg::*;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  class distance_scoreboard;
    logic signed [ELEM_W-1:0] inv_mat [4][4];
    logic [2:0] dims;
    logic root_mode;
    md_result_t pending[$];
    int errors;

    function new();
      dims = 3'd4;
      root_mode = 1'b1;
      errors = 0;
    endfunction

    function void set_regs(logic [2:0] d, logic r);
      dims = d;
      root_mode = r;
    endfunction

    function void report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function void note_item(md_item_t it);
      logic signed [DIFF_W-1:0] dv [4];
      logic signed [ACC_W-1:0] form, di, dj, mij;
      logic [ACC_W-1:0] x, res, cand;
      md_result_t r;
      int n;
      if (it.req_type == REQ_LOAD) begin
        for (int j = 0; j < 4; j++) inv_mat[it.row_index][j] = it.first_elem[j];
        return;
      end
      n = (dims > 4) ? 4 : int'(dims);
      for (int i = 0; i < n; i++)
        dv[i] = DIFF_W'(signed'(it.first_elem[i])) - DIFF_W'(signed'(it.second_elem[i]));
      form = '0;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          di = ACC_W'(dv[i]);
          dj = ACC_W'(dv[j]);
          mij = ACC_W'(inv_mat[i][j]);
          form += di * dj * mij;
        end
      r = '0;
      if (form < 0) begin
        r.negative_form = 1'b1;
      end else if (root_mode) begin
        x = form >> FRAC_W_SHIFT();
        res = '0;
        for (int b = 48; b >= 0; b--) begin
          cand = res | (ACC_W'(1) << b);
          if (cand * cand <= x) res = cand;
        end
        if (res > DIST_MAX) begin
          r.distance = DIST_MAX;
          r.saturated = 1'b1;
        end else r.distance = res[DIST_W-1:0];
      end else begin
        x = form >> (2 * FRAC_W_SHIFT());
        if (x > DIST_MAX) begin
          r.distance = DIST_MAX;
          r.saturated = 1'b1;
        end else r.distance = x[DIST_W-1:0];
      end
      pending.push_back(r);
    endfunction

    function int FRAC_W_SHIFT();
      return 16;
    endfunction

    function void check_result(md_result_t got);
      md_result_t want;
      if (pending.size() == 0) begin
        report("result with no item waiting");
        return;
      end
      want = pending.pop_front();
      if (got.distance !== want.distance)
        report($sformatf("distance %h, want %h", got.distance, want.distance));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated %b, want %b", got.saturated, want.saturated));
      if (got.negative_form !== want.negative_form)
        report($sformatf("negative_form %b, want %b", got.negative_form, want.negative_form));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit calm = 1'b0;
  bit long_hold = 1'b0;
  int out_wait = 0;

  md_if #(.payload_t(md_item_t)) in_ch ();
  md_if #(.payload_t(md_result_t)) out_ch ();

  distance_scoreboard sb = new();

  mahalanobis_distance uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_item(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  // result side: random stalls, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (out_wait > 0) begin
        out_ch.ready <= 1'b0;
        out_wait--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        out_wait = pick_gap() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return ELEM_W'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return $urandom();
    endcase
  endfunction

  function automatic md_item_t rand_item(logic kind);
    md_item_t it;
    it.req_type = kind;
    it.row_index = 2'($urandom_range(0, 3));
    for (int k = 0; k < 4; k++) begin
      it.first_elem[k] = rand_elem();
      it.second_elem[k] = rand_elem();
    end
    return it;
  endfunction

  function automatic md_item_t load_row(logic [1:0] row, logic [ELEM_W-1:0] c0,
                                        logic [ELEM_W-1:0] c1, logic [ELEM_W-1:0] c2,
                                        logic [ELEM_W-1:0] c3);
    md_item_t it = rand_item(REQ_LOAD);
    it.row_index = row;
    it.first_elem = {c3, c2, c1, c0};
    return it;
  endfunction

  function automatic md_item_t compute_vec(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
    md_item_t it = rand_item(REQ_COMPUTE);
    it.first_elem = {a, a, a, a};
    it.second_elem = {b, b, b, b};
    return it;
  endfunction

  task automatic send(md_item_t it);
    int gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // a load item may still be in flight
    repeat (80) @(posedge clk);
  endtask

  task automatic set_regs(logic [2:0] d, logic r);
    cfg_we <= 1'b1;
    cfg_index <= REG_DIMS;
    cfg_data <= d;
    @(posedge clk);
    cfg_index <= REG_ROOT;
    cfg_data <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(d, r);
  endtask

  initial begin
    logic [2:0] dims_list [7];
    logic root_list [7];
    dims_list = '{3'd4, 3'd4, 3'd1, 3'd7, 3'd0, 3'd2, 3'd3};
    root_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(3'd4, 1'b1);
    for (int r = 0; r < 4; r++) begin
      md_item_t it;
      it = load_row(r[1:0], 0, 0, 0, 0);
      it.first_elem[r] = 32'h0001_0000;
      send(it);
    end
    send(compute_vec(0, 0));
    send(compute_vec(32'h7fff_ffff, 32'h8000_0000));
    send(compute_vec(32'h8000_0000, 32'h7fff_ffff));
    send(compute_vec(32'h0000_0001, 0));
    send(load_row(2'd1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send(rand_item(REQ_COMPUTE));
    // negative diagonal in rows 0 to 2 drives the form below zero
    send(load_row(2'd0, 32'hffff_0000, 0, 0, 0));
    send(load_row(2'd1, 0, 32'hffff_0000, 0, 0));
    send(load_row(2'd2, 0, 0, 32'hffff_0000, 0));
    send(compute_vec(32'h0001_0000, 0));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      set_regs(dims_list[ph], root_list[ph]);
      calm = (ph == 2);
      for (int k = 0; k < 75; k++)
        send(rand_item(($urandom_range(0, 6) == 0) ? REQ_LOAD : REQ_COMPUTE));
      if (ph == 3) begin
        long_hold = 1'b1;
        for (int k = 0; k < 6; k++) send(rand_item(REQ_COMPUTE));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
